### rtl/iopse_pkg.sv
package iopse_pkg;

  localparam int DEF_EEPROM_DEPTH   = 8192;
  localparam int DEF_DATA_PIN_BIT   = 2;
  localparam int DEF_CLOCK_PIN_BIT  = 3;
  localparam int DEF_PULLUP_PATTERN = 255;

  // request types
  localparam logic [2:0] REQ_READ     = 3'd0;
  localparam logic [2:0] REQ_WRITE    = 3'd1;
  localparam logic [2:0] REQ_KEY_DOWN = 3'd2;
  localparam logic [2:0] REQ_KEY_UP   = 3'd3;
  localparam logic [2:0] REQ_SHOCK    = 3'd4;

  // register map
  localparam logic [7:0] ADDR_BATTERY = 8'h10;
  localparam logic [7:0] ADDR_MISC_44 = 8'h44;
  localparam logic [7:0] ADDR_MISC_45 = 8'h45;
  localparam logic [7:0] ADDR_MISC_46 = 8'h46;
  localparam logic [7:0] ADDR_MISC_47 = 8'h47;
  localparam logic [7:0] ADDR_PWR_50  = 8'h50;
  localparam logic [7:0] ADDR_PWR_51  = 8'h51;
  localparam logic [7:0] ADDR_KEYPAD  = 8'h52;
  localparam logic [7:0] ADDR_MISC_54 = 8'h54;
  localparam logic [7:0] ADDR_MISC_55 = 8'h55;
  localparam logic [7:0] ADDR_PIN_DIR = 8'h60;
  localparam logic [7:0] ADDR_PIN_DAT = 8'h61;
  localparam logic [7:0] ADDR_MISC_62 = 8'h62;

  localparam logic [7:0] MASK_44 = 8'hF7;
  localparam logic [7:0] MASK_54 = 8'h77;
  localparam logic [7:0] MASK_62 = 8'hF0;

  localparam logic [4:0] IRQ_KEY_BASE = 5'h1C;
  localparam logic [4:0] IRQ_SHOCK    = 5'h10;
  localparam int         RUMBLE_BIT   = 4;

  // eeprom bus phases
  localparam logic [2:0] PH_DEVICE_ID = 3'd0;
  localparam logic [2:0] PH_ADDR_HIGH = 3'd1;
  localparam logic [2:0] PH_ADDR_LOW  = 3'd2;
  localparam logic [2:0] PH_WRITE     = 3'd3;
  localparam logic [2:0] PH_READ      = 3'd4;

  localparam logic [3:0] DEV_ID_NIBBLE = 4'hA;
  localparam int         CNT_W         = 5;

  typedef struct packed {
    logic       en;
    logic [7:0] pins;
  } pin_req_t;

endpackage

### rtl/iopse_if.sv
interface iopse_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] reg_addr;
  logic [7:0] write_data;
  logic [2:0] key_index;

  modport source (output valid, req_type, reg_addr, write_data, key_index, input ready);
  modport sink (input valid, req_type, reg_addr, write_data, key_index, output ready);
endinterface

interface iopse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_valid;
  logic [4:0] irq_number;
  logic       rumble;

  modport source (output valid, read_data, irq_valid, irq_number, rumble, input ready);
  modport sink (input valid, read_data, irq_valid, irq_number, rumble, output ready);
endinterface

interface iopse_cfg_if;
  logic valid;
  logic ready;
  logic battery_low;

  modport source (output valid, battery_low, input ready);
  modport sink (input valid, battery_low, output ready);
endinterface

### rtl/iopse_i2c.sv
module iopse_i2c import iopse_pkg::*; #(
  parameter int EEPROM_DEPTH  = DEF_EEPROM_DEPTH,
  parameter int DATA_PIN_BIT  = DEF_DATA_PIN_BIT,
  parameter int CLOCK_PIN_BIT = DEF_CLOCK_PIN_BIT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  pin_req_t pin_req,
  output logic     sda_bit
);

  // store is indexed by the low address bits; depth must be a power of two, which is not checked
  localparam int AW = $clog2(EEPROM_DEPTH);

  logic [7:0]              last_pins_r, last_pins_nxt;
  logic                    listening_r, listening_nxt;
  logic [2:0]              phase_r, phase_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]              shift_r, shift_nxt;
  logic [15:0]             addr_r, addr_nxt;

  logic [7:0]    mem [EEPROM_DEPTH];
  logic [7:0]    mem_q_r;
  logic          mem_we;
  logic [AW-1:0] rd_idx;

  logic [7:0] rise, fall;
  logic       start_cond, stop_cond;

  assign rise       = pin_req.pins & ~last_pins_r;
  assign fall       = ~pin_req.pins & last_pins_r;
  assign start_cond = pin_req.en && fall[DATA_PIN_BIT] && pin_req.pins[CLOCK_PIN_BIT];
  assign stop_cond  = pin_req.en && rise[DATA_PIN_BIT] && pin_req.pins[CLOCK_PIN_BIT];

  always_comb begin
    last_pins_nxt = last_pins_r;
    listening_nxt = listening_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    addr_nxt      = addr_r;
    mem_we        = 1'b0;
    if (pin_req.en) begin
      last_pins_nxt = pin_req.pins;
      if (start_cond) begin
        listening_nxt = 1'b1;
        phase_nxt     = PH_DEVICE_ID;
        cnt_nxt       = CNT_W'(8);
        shift_nxt     = 8'h00;
      end else if (stop_cond) begin
        listening_nxt = 1'b0;
      end else if (listening_r) begin
        if (rise[CLOCK_PIN_BIT]) begin
          if (cnt_r < 0) begin
            cnt_nxt   = CNT_W'(8);
            shift_nxt = 8'h00;
            unique case (phase_r)
              PH_DEVICE_ID: begin
                if (shift_r[7:4] == DEV_ID_NIBBLE)
                  phase_nxt = shift_r[0] ? PH_READ : PH_ADDR_HIGH;
              end
              PH_ADDR_HIGH: begin
                addr_nxt  = {shift_r, addr_r[7:0]};
                phase_nxt = PH_ADDR_LOW;
              end
              PH_ADDR_LOW: begin
                addr_nxt  = {addr_r[15:8], shift_r};
                phase_nxt = PH_WRITE;
              end
              PH_WRITE: begin
                mem_we   = 1'b1;
                addr_nxt = addr_r + 16'd1;
              end
              PH_READ: begin
                addr_nxt = addr_r + 16'd1;
              end
              default: ;
            endcase
          end else begin
            shift_nxt = {shift_r[6:0], pin_req.pins[DATA_PIN_BIT]};
          end
        end else if (fall[CLOCK_PIN_BIT]) begin
          if (cnt_r > -CNT_W'(16))
            cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pins_r <= 8'h00;
      listening_r <= 1'b0;
      phase_r     <= PH_DEVICE_ID;
      cnt_r       <= '0;
      shift_r     <= 8'h00;
      addr_r      <= 16'h0000;
    end else begin
      last_pins_r <= last_pins_nxt;
      listening_r <= listening_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      addr_r      <= addr_nxt;
    end
  end

  // read port follows the next address so mem_q_r always holds the addressed byte;
  // the write goes to the old address, which never equals the new one
  assign rd_idx = rst_n ? addr_nxt[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (mem_we)
      mem[addr_r[AW-1:0]] <= shift_r;
    mem_q_r <= mem[rd_idx];
  end

  // acknowledge slot and idle bus read low and high respectively
  always_comb begin
    if (!listening_r)
      sda_bit = 1'b1;
    else if (cnt_r < 0 || cnt_r > CNT_W'(7))
      sda_bit = 1'b0;
    else if (phase_r == PH_READ)
      sda_bit = mem_q_r[cnt_r[2:0]];
    else
      sda_bit = 1'b1;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r >= -CNT_W'(1) && cnt_r <= CNT_W'(8))
    else $error("bit counter out of range");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start_cond |=> listening_r && cnt_r == CNT_W'(8) && phase_r == PH_DEVICE_ID)
    else $error("start condition not taken");

  a_wr_incr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> addr_r == 16'($past(addr_r) + 16'd1))
    else $error("address not advanced after store write");

endmodule

### rtl/io_port_with_serial_eeprom.sv
// I/O register block with keypad, GPIO pins and a bit-banged serial EEPROM slave.
// in_ch carries requests: register read, register write, key down, key up, shock.
// out_ch returns one result per request: read byte, interrupt flag and number,
// and the rumble drive after the request.
// cfg_ch writes the low battery flag; it is always ready and is meant for idle times.
// A request accepted at a clock edge has its result registered and valid right after that
// edge; one request per cycle is sustained while out_ch takes the results, as the request
// updates the register file and the EEPROM slave state at the edge that accepts it.
// The store has one write port and one registered read port that tracks the current
// EEPROM address, so a pin read in the read phase finds the addressed byte already there.
// When out_ch stalls, the result register holds and in_ch is accepted only in a cycle
// in which the result register empties or is empty.
// Reset clears the state registers to their idle values (keypad to all keys up, bus idle);
// the result data registers and the EEPROM store keep their contents and need no clearing.
// EEPROM_DEPTH must be a power of two; the block itself does not enforce it.
module io_port_with_serial_eeprom import iopse_pkg::*; #(
  parameter int EEPROM_DEPTH   = DEF_EEPROM_DEPTH,
  parameter int DATA_PIN_BIT   = DEF_DATA_PIN_BIT,
  parameter int CLOCK_PIN_BIT  = DEF_CLOCK_PIN_BIT,
  parameter int PULLUP_PATTERN = DEF_PULLUP_PATTERN
) (
  input logic        clk,
  input logic        rst_n,
  iopse_in_if.sink   in_ch,
  iopse_out_if.source out_ch,
  iopse_cfg_if.sink  cfg_ch
);

  localparam logic [7:0] DAT_MASK = 8'(1) << DATA_PIN_BIT;
  localparam logic [7:0] PULLUP   = 8'(PULLUP_PATTERN);

  logic       batt_low_r;
  logic [4:0] batt_bits_r, batt_bits_nxt;
  logic [7:0] m44_r, m44_nxt;
  logic [3:0] m45_r, m45_nxt;
  logic [7:0] m46_r, m46_nxt;
  logic [3:0] m47_r, m47_nxt;
  logic [7:0] p50_r, p50_nxt;
  logic [1:0] p51_r, p51_nxt;
  logic [7:0] m54_r, m54_nxt;
  logic [2:0] m55_r, m55_nxt;
  logic [7:0] m62_r, m62_nxt;
  logic [7:0] key_bits_r, key_bits_nxt;
  logic [7:0] dir_r, dir_nxt;
  logic [7:0] dat_r, dat_nxt;
  logic       rumble_r, rumble_nxt;

  logic       out_valid_r;
  logic [7:0] out_rd_r, rd;
  logic       out_irq_r, irq;
  logic [4:0] out_num_r, num;

  logic       acc;
  logic       in_ready;
  logic [7:0] kbit;
  logic [7:0] pins;
  logic       pin_en;
  logic       sda_bit;
  pin_req_t   pin_req;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;
  assign cfg_ch.ready = 1'b1;
  assign kbit        = 8'(1) << in_ch.key_index;

  always_comb begin
    batt_bits_nxt = batt_bits_r;
    m44_nxt = m44_r;
    m45_nxt = m45_r;
    m46_nxt = m46_r;
    m47_nxt = m47_r;
    p50_nxt = p50_r;
    p51_nxt = p51_r;
    m54_nxt = m54_r;
    m55_nxt = m55_r;
    m62_nxt = m62_r;
    key_bits_nxt = key_bits_r;
    dir_nxt = dir_r;
    dat_nxt = dat_r;
    rd  = 8'h00;
    irq = 1'b0;
    num = 5'd0;
    pin_en = 1'b0;
    if (acc) begin
      unique case (in_ch.req_type)
        REQ_READ: begin
          unique case (in_ch.reg_addr)
            ADDR_BATTERY: rd = {2'b00, batt_low_r, batt_bits_r};
            ADDR_MISC_44: rd = m44_r;
            ADDR_MISC_45: rd = {4'h0, m45_r};
            ADDR_MISC_46: rd = m46_r;
            ADDR_MISC_47: rd = {4'h0, m47_r};
            ADDR_PWR_50:  rd = p50_r;
            ADDR_PWR_51:  rd = {6'h00, p51_r};
            ADDR_KEYPAD:  rd = key_bits_r;
            ADDR_MISC_54: rd = m54_r;
            ADDR_MISC_55: rd = {5'h00, m55_r};
            ADDR_PIN_DIR: rd = dir_r;
            ADDR_PIN_DAT: rd = (dat_r & dir_r) | ((sda_bit ? DAT_MASK : 8'h00) & ~dir_r);
            ADDR_MISC_62: rd = m62_r;
            default:      rd = 8'h00;
          endcase
        end
        REQ_WRITE: begin
          unique case (in_ch.reg_addr)
            ADDR_BATTERY: batt_bits_nxt = in_ch.write_data[4:0];
            ADDR_MISC_44: m44_nxt = in_ch.write_data & MASK_44;
            ADDR_MISC_45: m45_nxt = in_ch.write_data[3:0];
            ADDR_MISC_46: m46_nxt = in_ch.write_data;
            ADDR_MISC_47: m47_nxt = in_ch.write_data[3:0];
            ADDR_PWR_50:  p50_nxt = in_ch.write_data;
            ADDR_PWR_51:  p51_nxt = in_ch.write_data[1:0];
            ADDR_MISC_54: m54_nxt = in_ch.write_data & MASK_54;
            ADDR_MISC_55: m55_nxt = in_ch.write_data[2:0];
            ADDR_PIN_DIR: begin
              dir_nxt = in_ch.write_data;
              pin_en  = 1'b1;
            end
            ADDR_PIN_DAT: begin
              dat_nxt = in_ch.write_data;
              pin_en  = 1'b1;
            end
            ADDR_MISC_62: m62_nxt = in_ch.write_data & MASK_62;
            default: ;
          endcase
        end
        REQ_KEY_DOWN: begin
          if ((key_bits_r & kbit) != 8'h00) begin
            irq = 1'b1;
            num = IRQ_KEY_BASE - {2'b00, in_ch.key_index};
            key_bits_nxt = key_bits_r & ~kbit;
          end
        end
        REQ_KEY_UP: key_bits_nxt = key_bits_r | kbit;
        REQ_SHOCK: begin
          irq = 1'b1;
          num = IRQ_SHOCK;
        end
        default: ;
      endcase
    end
  end

  // undriven pins float to the pull-up pattern
  assign pins       = (dat_nxt & dir_nxt) | (PULLUP & ~dir_nxt);
  assign pin_req    = {pin_en, pins};
  assign rumble_nxt = pin_en ? pins[RUMBLE_BIT] : rumble_r;

  iopse_i2c #(
    .EEPROM_DEPTH (EEPROM_DEPTH),
    .DATA_PIN_BIT (DATA_PIN_BIT),
    .CLOCK_PIN_BIT(CLOCK_PIN_BIT)
  ) u_i2c (
    .clk    (clk),
    .rst_n  (rst_n),
    .pin_req(pin_req),
    .sda_bit(sda_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batt_low_r  <= 1'b0;
      batt_bits_r <= 5'h00;
      m44_r <= 8'h00;
      m45_r <= 4'h0;
      m46_r <= 8'h00;
      m47_r <= 4'h0;
      p50_r <= 8'h00;
      p51_r <= 2'b00;
      m54_r <= 8'h00;
      m55_r <= 3'b000;
      m62_r <= 8'h00;
      key_bits_r  <= 8'hFF;
      dir_r       <= 8'h00;
      dat_r       <= 8'h00;
      rumble_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid)
        batt_low_r <= cfg_ch.battery_low;
      batt_bits_r <= batt_bits_nxt;
      m44_r <= m44_nxt;
      m45_r <= m45_nxt;
      m46_r <= m46_nxt;
      m47_r <= m47_nxt;
      p50_r <= p50_nxt;
      p51_r <= p51_nxt;
      m54_r <= m54_nxt;
      m55_r <= m55_nxt;
      m62_r <= m62_nxt;
      key_bits_r <= key_bits_nxt;
      dir_r      <= dir_nxt;
      dat_r      <= dat_nxt;
      rumble_r   <= rumble_nxt;
      if (acc)
        out_valid_r <= 1'b1;
      else if (out_ch.ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_rd_r  <= rd;
      out_irq_r <= irq;
      out_num_r <= num;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_rd_r;
  assign out_ch.irq_valid  = out_irq_r;
  assign out_ch.irq_number = out_num_r;
  assign out_ch.rumble     = rumble_r;

  a_key_down_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_ch.req_type == REQ_KEY_DOWN |=> key_bits_r == ($past(key_bits_r) & ~$past(kbit)))
    else $error("key press did not clear keypad bit");

  a_irq_has_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_irq_r |-> out_num_r == 5'd0)
    else $error("interrupt number without interrupt");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !acc)
    else $error("request taken while result stalled");

endmodule

### tb/iopse_sb_pkg.sv
`timescale 1ns / 100ps

package iopse_sb_pkg;
  import iopse_pkg::*;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [2:0] key_index;
  } io_request_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_valid;
    logic [4:0] irq_number;
    logic       rumble;
  } io_result_t;

  class io_port_scoreboard;
    bit         battery_low;
    bit [4:0]   battery_bits;
    bit [7:0]   reg_44, reg_45, reg_46, reg_47, reg_50, reg_51, reg_54, reg_55, reg_62;
    bit [7:0]   keys_n;
    bit [7:0]   pin_dir, pin_dat, last_pins;
    bit         rumble_on;
    bit         listening;
    bit [2:0]   phase;
    int         bit_cnt;
    bit [7:0]   shift_reg;
    bit [15:0]  ee_addr;
    bit [7:0]   ee_mem [DEF_EEPROM_DEPTH];
    bit         ee_known [DEF_EEPROM_DEPTH];
    io_result_t due_results [$];
    int         errors;
    int         checked;

    function new();
      keys_n = 8'hFF;
      phase  = PH_DEVICE_ID;
    endfunction

    function void set_battery_low(bit v);
      battery_low = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function int ee_index();
      return int'(ee_addr) % DEF_EEPROM_DEPTH;
    endfunction

    function void take_byte(bit [7:0] b);
      case (phase)
        PH_DEVICE_ID: if (b[7:4] == DEV_ID_NIBBLE) phase = b[0] ? PH_READ : PH_ADDR_HIGH;
        PH_ADDR_HIGH: begin
          ee_addr[15:8] = b;
          phase = PH_ADDR_LOW;
        end
        PH_ADDR_LOW: begin
          ee_addr[7:0] = b;
          phase = PH_WRITE;
        end
        PH_WRITE: begin
          ee_mem[ee_index()]   = b;
          ee_known[ee_index()] = 1'b1;
          ee_addr++;
        end
        PH_READ: ee_addr++;
        default: ;
      endcase
    endfunction

    function void bus_event(bit [7:0] pins);
      bit [7:0] rise_bits;
      bit [7:0] fall_bits;
      rise_bits = pins & ~last_pins;
      fall_bits = ~pins & last_pins;
      last_pins = pins;
      // data edge while clock is high: start or stop
      if (fall_bits[DEF_DATA_PIN_BIT] && pins[DEF_CLOCK_PIN_BIT]) begin
        listening = 1'b1;
        phase     = PH_DEVICE_ID;
        bit_cnt   = 8;
        shift_reg = 8'h00;
        return;
      end
      if (rise_bits[DEF_DATA_PIN_BIT] && pins[DEF_CLOCK_PIN_BIT]) begin
        listening = 1'b0;
        return;
      end
      if (!listening) return;
      if (rise_bits[DEF_CLOCK_PIN_BIT]) begin
        if (bit_cnt < 0) begin
          take_byte(shift_reg);
          bit_cnt   = 8;
          shift_reg = 8'h00;
        end else begin
          shift_reg = {shift_reg[6:0], pins[DEF_DATA_PIN_BIT]};
        end
      end else if (fall_bits[DEF_CLOCK_PIN_BIT]) begin
        if (bit_cnt > -16) bit_cnt--;
      end
    endfunction

    function void drive_pins();
      bit [7:0] pins;
      pins = (pin_dat & pin_dir) | (8'(DEF_PULLUP_PATTERN) & ~pin_dir);
      rumble_on = pins[RUMBLE_BIT];
      bus_event(pins);
    endfunction

    function bit slave_bit();
      if (!listening) return 1'b1;
      if (bit_cnt < 0 || bit_cnt > 7) return 1'b0;
      if (phase == PH_READ) return ee_mem[ee_index()][bit_cnt];
      return 1'b1;
    endfunction

    function bit [7:0] read_reg(bit [7:0] a);
      bit [7:0] din;
      case (a)
        ADDR_BATTERY: return {2'b00, battery_low, battery_bits};
        ADDR_MISC_44: return reg_44;
        ADDR_MISC_45: return reg_45;
        ADDR_MISC_46: return reg_46;
        ADDR_MISC_47: return reg_47;
        ADDR_PWR_50:  return reg_50;
        ADDR_PWR_51:  return reg_51;
        ADDR_KEYPAD:  return keys_n;
        ADDR_MISC_54: return reg_54;
        ADDR_MISC_55: return reg_55;
        ADDR_PIN_DIR: return pin_dir;
        ADDR_PIN_DAT: begin
          din = 8'h00;
          din[DEF_DATA_PIN_BIT] = slave_bit();
          return (pin_dat & pin_dir) | (din & ~pin_dir);
        end
        ADDR_MISC_62: return reg_62;
        default:      return 8'h00;
      endcase
    endfunction

    function void write_reg(bit [7:0] a, bit [7:0] v);
      case (a)
        ADDR_BATTERY: battery_bits = v[4:0];
        ADDR_MISC_44: reg_44 = v & MASK_44;
        ADDR_MISC_45: reg_45 = v & 8'h0F;
        ADDR_MISC_46: reg_46 = v;
        ADDR_MISC_47: reg_47 = v & 8'h0F;
        ADDR_PWR_50:  reg_50 = v;
        ADDR_PWR_51:  reg_51 = v & 8'h03;
        ADDR_MISC_54: reg_54 = v & MASK_54;
        ADDR_MISC_55: reg_55 = v & 8'h07;
        ADDR_PIN_DIR: begin
          pin_dir = v;
          drive_pins();
        end
        ADDR_PIN_DAT: begin
          pin_dat = v;
          drive_pins();
        end
        ADDR_MISC_62: reg_62 = v & MASK_62;
        default: ;
      endcase
    endfunction

    // true when a pin read would sample a store cell with no known contents
    function bit reads_unwritten_cell(io_request_t r);
      return r.req_type == REQ_READ && r.reg_addr == ADDR_PIN_DAT &&
             !pin_dir[DEF_DATA_PIN_BIT] && listening && phase == PH_READ &&
             bit_cnt >= 0 && bit_cnt <= 7 && !ee_known[ee_index()];
    endfunction

    function void note_request(io_request_t r);
      io_result_t res;
      bit [7:0]   kbit;
      res  = '0;
      kbit = 8'b1 << r.key_index;
      case (r.req_type)
        REQ_READ:  res.read_data = read_reg(r.reg_addr);
        REQ_WRITE: write_reg(r.reg_addr, r.write_data);
        REQ_KEY_DOWN: begin
          if (keys_n & kbit) begin
            res.irq_valid  = 1'b1;
            res.irq_number = IRQ_KEY_BASE - 5'(r.key_index);
            keys_n = keys_n & ~kbit;
          end
        end
        REQ_KEY_UP: keys_n = keys_n | kbit;
        REQ_SHOCK: begin
          res.irq_valid  = 1'b1;
          res.irq_number = IRQ_SHOCK;
        end
        default: ;
      endcase
      res.rumble = rumble_on;
      due_results.push_back(res);
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 100) $display("mismatch on result %0d: %s", checked, what);
    endfunction

    function void check_result(io_result_t got);
      io_result_t want;
      checked++;
      if (due_results.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = due_results.pop_front();
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.irq_valid !== want.irq_valid)
        report($sformatf("irq_valid %b, want %b", got.irq_valid, want.irq_valid));
      if (got.irq_number !== want.irq_number)
        report($sformatf("irq_number %h, want %h", got.irq_number, want.irq_number));
      if (got.rumble !== want.rumble)
        report($sformatf("rumble %b, want %b", got.rumble, want.rumble));
    endfunction
  endclass

endpackage

### tb/io_port_with_serial_eeprom_tb.sv
`timescale 1ns / 100ps

module io_port_with_serial_eeprom_tb;
  import iopse_pkg::*;
  import iopse_sb_pkg::*;

  localparam int         DAT_BIT      = DEF_DATA_PIN_BIT;
  localparam int         CLK_BIT      = DEF_CLOCK_PIN_BIT;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [7:0] ADDR_DEAD_53 = 8'h53;
  localparam logic [7:0] ADDR_UNUSED  = 8'hFF;

  typedef struct {
    logic [15:0] addr;
    int          count;
  } ee_span_t;

  logic clk;
  logic rst_n;

  iopse_in_if  in_ch();
  iopse_out_if out_ch();
  iopse_cfg_if cfg_ch();

  io_port_with_serial_eeprom i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  io_port_scoreboard sb;
  io_result_t        seen;
  int                in_gap_pct;
  int                out_stall_pct;
  int                sent;
  int                cycles;
  bit                bus_clk;
  bit                bus_dat;
  ee_span_t          spans [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[io_port_with_serial_eeprom] ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.read_data  = out_ch.read_data;
      seen.irq_valid  = out_ch.irq_valid;
      seen.irq_number = out_ch.irq_number;
      seen.rumble     = out_ch.rumble;
      sb.check_result(seen);
    end
  end

  // called and returns at a falling edge
  task automatic send(logic [2:0] kind, logic [7:0] addr, logic [7:0] data, logic [2:0] key);
    io_request_t r;
    r.req_type   = kind;
    r.reg_addr   = addr;
    r.write_data = data;
    r.key_index  = key;
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    // a store cell that was never written has no known contents
    if (sb.reads_unwritten_cell(r)) r.reg_addr = ADDR_PIN_DIR;
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= r.req_type;
    in_ch.reg_addr   <= r.reg_addr;
    in_ch.write_data <= r.write_data;
    in_ch.key_index  <= r.key_index;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic load_battery_flag(bit v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.battery_low <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_battery_low(v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_reg();
    case ($urandom_range(13))
      0:  return ADDR_BATTERY;
      1:  return ADDR_MISC_44;
      2:  return ADDR_MISC_45;
      3:  return ADDR_MISC_46;
      4:  return ADDR_MISC_47;
      5:  return ADDR_PWR_50;
      6:  return ADDR_PWR_51;
      7:  return ADDR_KEYPAD;
      8:  return ADDR_DEAD_53;
      9:  return ADDR_MISC_54;
      10: return ADDR_MISC_55;
      11: return ADDR_PIN_DIR;
      12: return ADDR_PIN_DAT;
      default: return ADDR_MISC_62;
    endcase
  endfunction

  // any request that leaves the pins alone
  task automatic send_noise();
    logic [2:0] kind;
    logic [7:0] addr;
    kind = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    addr = $urandom_range(1) ? pick_reg() : 8'($urandom);
    if (kind == REQ_WRITE && (addr == ADDR_PIN_DIR || addr == ADDR_PIN_DAT)) kind = REQ_READ;
    send(kind, addr, 8'($urandom), 3'($urandom));
  endtask

  task automatic set_pins(bit c, bit d);
    logic [7:0] v;
    v = 8'($urandom);
    v[CLK_BIT] = c;
    v[DAT_BIT] = d;
    send(REQ_WRITE, ADDR_PIN_DAT, v, 3'($urandom));
    bus_clk = c;
    bus_dat = d;
    if ($urandom_range(99) < 12) send_noise();
  endtask

  task automatic set_dir(bit drive_dat);
    logic [7:0] v;
    v = 8'($urandom);
    v[CLK_BIT] = 1'b1;
    v[DAT_BIT] = drive_dat;
    send(REQ_WRITE, ADDR_PIN_DIR, v, 3'($urandom));
  endtask

  task automatic init_bus();
    set_pins(1'b1, 1'b1);
    set_dir(1'b1);
  endtask

  task automatic bus_start();
    if (!bus_dat) set_pins(1'b0, 1'b1);
    if (!bus_clk) set_pins(1'b1, 1'b1);
    set_pins(1'b1, 1'b0);
  endtask

  task automatic bus_stop();
    set_pins(1'b0, 1'b0);
    set_pins(1'b1, 1'b0);
    set_pins(1'b1, 1'b1);
  endtask

  // leaves the clock high after the acknowledge clock
  task automatic send_byte(logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      set_pins(1'b0, b[i]);
      set_pins(1'b1, b[i]);
    end
    set_pins(1'b0, 1'b1);
    if ($urandom_range(1)) begin
      // release the line and look at the acknowledge
      set_dir(1'b0);
      send(REQ_READ, ADDR_PIN_DAT, 8'($urandom), 3'($urandom));
      set_dir(1'b1);
    end
    set_pins(1'b1, 1'b1);
  endtask

  task automatic read_bytes(int n);
    set_dir(1'b0);
    repeat (n) begin
      for (int i = 0; i < 8; i++) begin
        set_pins(1'b0, 1'b1);
        send(REQ_READ, ADDR_PIN_DAT, 8'($urandom), 3'($urandom));
        set_pins(1'b1, 1'b1);
      end
      // master acknowledge clock moves the address on
      set_pins(1'b0, 1'b1);
      set_pins(1'b1, 1'b1);
    end
    set_dir(1'b1);
  endtask

  task automatic eeprom_write_txn();
    logic [15:0] a;
    logic [3:0]  nib;
    int          n;
    bit          foreign;
    bit          cut;
    a       = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
    n       = $urandom_range(3, 1);
    foreign = ($urandom_range(9) == 0);
    cut     = ($urandom_range(9) == 0);
    nib     = DEV_ID_NIBBLE;
    if (foreign) begin
      nib = 4'($urandom_range(14));
      if (nib >= DEV_ID_NIBBLE) nib = nib + 4'd1;
    end
    init_bus();
    bus_start();
    send_byte({nib, 3'($urandom), 1'b0});
    send_byte(a[15:8]);
    if (!cut) begin
      send_byte(a[7:0]);
      repeat (n) send_byte(8'($urandom));
    end
    bus_stop();
    if (!foreign && !cut) spans.push_back('{addr: a, count: n});
  endtask

  task automatic eeprom_read_txn();
    ee_span_t s;
    if (spans.size() == 0) begin
      eeprom_write_txn();
      return;
    end
    s = spans[$urandom_range(spans.size() - 1)];
    init_bus();
    bus_start();
    // mostly a random read; sometimes read on from the current address
    if ($urandom_range(4) != 0) begin
      send_byte({DEV_ID_NIBBLE, 3'($urandom), 1'b0});
      send_byte(s.addr[15:8]);
      send_byte(s.addr[7:0]);
      bus_start();
    end
    send_byte({DEV_ID_NIBBLE, 3'($urandom), 1'b1});
    read_bytes(s.count);
    bus_stop();
  endtask

  task automatic run_random_phase(int n);
    int stop_at;
    stop_at = sent + n;
    while (sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3: eeprom_write_txn();
        4, 5, 6, 7: eeprom_read_txn();
        8: repeat ($urandom_range(6, 1)) send_noise();
        default: send(REQ_WRITE, $urandom_range(1) ? ADDR_PIN_DIR : ADDR_PIN_DAT,
                      8'($urandom), 3'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new();
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_READ;
    in_ch.reg_addr     = 8'h00;
    in_ch.write_data   = 8'h00;
    in_ch.key_index    = 3'd0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.battery_low = 1'b0;
    in_gap_pct         = 32;
    out_stall_pct      = 77;
    rst_n              = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    load_battery_flag(1'b1);

    send(REQ_READ, ADDR_BATTERY, 8'h00, 3'd0);
    send(REQ_WRITE, ADDR_BATTERY, 8'hFF, 3'd7);
    send(REQ_READ, ADDR_BATTERY, 8'h00, 3'd0);
    // writes to 0x53..0x55 stay out of the direction register
    send(REQ_WRITE, ADDR_DEAD_53, 8'hFF, 3'd0);
    send(REQ_WRITE, ADDR_MISC_54, 8'hFF, 3'd0);
    send(REQ_WRITE, ADDR_MISC_55, 8'hFF, 3'd0);
    send(REQ_READ, ADDR_PIN_DIR, 8'h00, 3'd0);
    send(REQ_READ, ADDR_DEAD_53, 8'h00, 3'd0);
    send(REQ_READ, ADDR_MISC_54, 8'h00, 3'd0);
    send(REQ_READ, ADDR_MISC_55, 8'h00, 3'd0);
    send(REQ_WRITE, ADDR_KEYPAD, 8'h00, 3'd0);
    send(REQ_KEY_DOWN, 8'h00, 8'h00, 3'd0);
    send(REQ_KEY_DOWN, 8'h00, 8'h00, 3'd0);
    send(REQ_KEY_DOWN, 8'hFF, 8'hFF, 3'd7);
    send(REQ_KEY_DOWN, 8'h00, 8'h00, 3'd3);
    send(REQ_READ, ADDR_KEYPAD, 8'h00, 3'd0);
    send(REQ_KEY_UP, 8'h00, 8'h00, 3'd0);
    send(REQ_KEY_UP, 8'h00, 8'h00, 3'd7);
    send(REQ_SHOCK, 8'h00, 8'h00, 3'd0);
    send(3'd5, 8'hFF, 8'hFF, 3'd7);
    send(3'd7, 8'h00, 8'h00, 3'd0);
    send(REQ_READ, ADDR_UNUSED, 8'h00, 3'd0);
    send(REQ_WRITE, ADDR_PIN_DIR, 8'hFF, 3'd0);
    send(REQ_WRITE, ADDR_PIN_DAT, 8'h10, 3'd0);
    send(REQ_READ, ADDR_PIN_DAT, 8'h00, 3'd0);
    send(REQ_WRITE, ADDR_PIN_DIR, 8'h00, 3'd0);

    // each phase runs on to the end of its last transaction
    run_random_phase(60);
    settle();
    run_random_phase(60);

    settle();
    in_gap_pct    = 77;
    out_stall_pct = 32;
    load_battery_flag(1'b0);
    run_random_phase(160);

    settle();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    load_battery_flag(1'b1);
    run_random_phase(160);

    settle();
    if (sb.errors == 0) begin
      $display("[io_port_with_serial_eeprom] OK");
    end else begin
      $display("[io_port_with_serial_eeprom] ERROR");
    end
    $finish;
  end

endmodule
